// File: rtl/assert_macros.svh
// Assertion macros shared by the converter RTL.
// Included by the modules that carry concurrent checks; depends on nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// File: rtl/sitda_pkg.sv
// Package for the signed integer to decimal ASCII converter.
// Holds character codes, widths, the digit-count function and the number info type.
`timescale 1ns / 1ps

package sitda_pkg;

  localparam int unsigned VALUE_BITS_DEF = 32;
  localparam int unsigned DABBLE_BITS    = 4;
  localparam int unsigned DIG_IDX_W      = 5;
  localparam int unsigned CHAR_W         = 8;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;
  localparam logic [63:0]       RADIX    = 64'd10;

  // Decimal digits needed for the largest magnitude, 2^(bits-1).
  function automatic int unsigned num_digits(input int unsigned bits);
    logic [63:0] v;
    int unsigned n;
    v = 64'd1 << (bits - 1);
    n = 0;
    while (v != 64'd0) begin
      n++;
      v = v / RADIX;
    end
    return n;
  endfunction

  typedef struct packed {
    logic                 neg;
    logic [DIG_IDX_W-1:0] top_idx;
  } num_info_t;

endpackage

// File: rtl/sitda_bcd_pipe.sv
// Conversion pipeline: magnitude stage, double-dabble stages, digit-length stage.
// Depends on sitda_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sitda_bcd_pipe #(
  parameter int unsigned VALUE_BITS = sitda_pkg::VALUE_BITS_DEF,
  localparam int unsigned NumDigits = sitda_pkg::num_digits(VALUE_BITS)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [VALUE_BITS-1:0] value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [NumDigits*4-1:0]      bcd_o,
  output sitda_pkg::num_info_t        info_o
);
  import sitda_pkg::*;

  localparam int unsigned NumStages = (VALUE_BITS + DABBLE_BITS - 1) / DABBLE_BITS;
  localparam int unsigned PadW      = NumStages * DABBLE_BITS;
  localparam int unsigned BcdW      = NumDigits * 4;
  localparam int unsigned IdxW      = $clog2(NumDigits);
  localparam int unsigned LenStg    = NumStages + 1;

  function automatic logic [BcdW+PadW-1:0] dabble(input logic [BcdW+PadW-1:0] x);
    logic [BcdW+PadW-1:0] r;
    r = x;
    for (int b = 0; b < DABBLE_BITS; b++) begin
      for (int d = 0; d < NumDigits; d++) begin
        if (r[PadW+4*d +: 4] >= 4'd5) begin
          r[PadW+4*d +: 4] = r[PadW+4*d +: 4] + 4'd3;
        end
      end
      r = r << 1;
    end
    return r;
  endfunction

  logic [LenStg:0]       vld_q;
  logic [LenStg+1:0]     ld;
  logic [PadW-1:0]       mag_q [NumStages];
  logic [BcdW-1:0]       bcd_q [1:LenStg];
  logic                  neg_q [LenStg+1];
  logic [IdxW-1:0]       top_q;
  logic [IdxW-1:0]       top_d;
  logic [VALUE_BITS-1:0] neg_mag;
  logic [PadW-1:0]       mag_d;
  logic [LenStg:0]       hold_v;
  logic                  bcd_ok;

  assign ld[LenStg+1] = out_ready_i;
  for (genvar s = 0; s <= LenStg; s++) begin : g_ld
    assign ld[s] = !vld_q[s] || ld[s+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (ld[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int s = 1; s <= LenStg; s++) begin
        if (ld[s]) begin
          vld_q[s] <= vld_q[s-1];
        end
      end
    end
  end

  assign neg_mag = ~value_i + 1'b1;
  assign mag_d   = value_i[VALUE_BITS-1] ? PadW'(neg_mag)
                                         : PadW'(unsigned'(value_i));

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      mag_q[0] <= mag_d;
      neg_q[0] <= value_i[VALUE_BITS-1];
    end
  end

  for (genvar s = 1; s <= NumStages; s++) begin : g_stage
    logic [BcdW-1:0]      bcd_in;
    logic [BcdW+PadW-1:0] res;

    if (s == 1) begin : g_first
      assign bcd_in = '0;
    end else begin : g_rest
      assign bcd_in = bcd_q[s-1];
    end
    assign res = dabble({bcd_in, mag_q[s-1]});

    always_ff @(posedge clk_i) begin
      if (ld[s]) begin
        bcd_q[s] <= res[PadW +: BcdW];
        neg_q[s] <= neg_q[s-1];
      end
    end

    if (s < NumStages) begin : g_mag
      always_ff @(posedge clk_i) begin
        if (ld[s]) begin
          mag_q[s] <= res[PadW-1:0];
        end
      end
    end
  end

  always_comb begin
    top_d = '0;
    for (int d = 1; d < NumDigits; d++) begin
      if (bcd_q[NumStages][4*d +: 4] != 4'd0) begin
        top_d = IdxW'(d);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[LenStg]) begin
      bcd_q[LenStg] <= bcd_q[NumStages];
      neg_q[LenStg] <= neg_q[NumStages];
      top_q         <= top_d;
    end
  end

  assign in_ready_o     = ld[0];
  assign out_valid_o    = vld_q[LenStg];
  assign bcd_o          = bcd_q[LenStg];
  assign info_o.neg     = neg_q[LenStg];
  assign info_o.top_idx = DIG_IDX_W'(top_q);

  assign hold_v = vld_q & ~ld[LenStg+1:1];

  always_comb begin
    bcd_ok = 1'b1;
    for (int d = 0; d < NumDigits; d++) begin
      if (bcd_q[LenStg][4*d +: 4] > 4'd9) begin
        bcd_ok = 1'b0;
      end
    end
  end

  `ASSERT_NEXT(a_stall_keeps_valid, clk_i, rst_ni, 1'b1, (vld_q & $past(hold_v)) == $past(hold_v))
  `ASSERT_IMPLIES(a_digits_decimal, clk_i, rst_ni, vld_q[LenStg], bcd_ok)
  `ASSERT_IMPLIES(a_top_digit_nonzero, clk_i, rst_ni, vld_q[LenStg], (top_q == '0) || (bcd_q[LenStg][4*top_q +: 4] != 4'd0))

endmodule

// File: rtl/sitda_emit.sv
// Character serializer: holds one converted number and sends its text with a registered output.
// Depends on sitda_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sitda_emit #(
  parameter int unsigned VALUE_BITS = sitda_pkg::VALUE_BITS_DEF,
  localparam int unsigned NumDigits = sitda_pkg::num_digits(VALUE_BITS)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [NumDigits*4-1:0]        bcd_i,
  input  sitda_pkg::num_info_t          info_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sitda_pkg::CHAR_W-1:0]  char_code_o,
  output logic                          last_char_o
);
  import sitda_pkg::*;

  localparam int unsigned BcdW = NumDigits * 4;
  localparam int unsigned IdxW = $clog2(NumDigits);

  logic              busy_q;
  logic              sign_q;
  logic [IdxW-1:0]   pos_q;
  logic [BcdW-1:0]   dig_q;
  logic              oval_q;
  logic [CHAR_W-1:0] char_q;
  logic              last_q;

  logic              out_take;
  logic              emit;
  logic              is_last;
  logic              finishing;
  logic              load;
  logic [CHAR_W-1:0] char_d;

  assign out_take  = !oval_q || out_ready_i;
  assign emit      = busy_q && out_take;
  assign is_last   = !sign_q && (pos_q == '0);
  assign finishing = emit && is_last;
  assign in_ready_o = !busy_q || finishing;
  assign load      = in_valid_i && in_ready_o;
  assign char_d    = sign_q ? CH_MINUS : (CH_ZERO + CHAR_W'(dig_q[4*pos_q +: 4]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      sign_q <= 1'b0;
      pos_q  <= '0;
    end else if (load) begin
      busy_q <= 1'b1;
      sign_q <= info_i.neg;
      pos_q  <= info_i.top_idx[IdxW-1:0];
    end else if (emit) begin
      if (sign_q) begin
        sign_q <= 1'b0;
      end else if (pos_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        pos_q <= pos_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      dig_q <= bcd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oval_q <= 1'b0;
    end else if (out_take) begin
      oval_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      char_q <= char_d;
      last_q <= is_last;
    end
  end

  assign out_valid_o = oval_q;
  assign char_code_o = char_q;
  assign last_char_o = last_q;

  `ASSERT_IMPLIES(a_last_is_digit, clk_i, rst_ni, oval_q && last_q, char_q != CH_MINUS)
  `ASSERT_NEXT(a_idle_after_last, clk_i, rst_ni, finishing && !in_valid_i, !busy_q)
  `ASSERT_IMPLIES(a_pos_in_range, clk_i, rst_ni, busy_q, 32'(pos_q) < NumDigits)

endmodule

// File: rtl/signed_int_to_decimal_ascii_top.sv
// Top level of the signed integer to decimal ASCII converter.
// Depends on sitda_pkg, sitda_bcd_pipe and sitda_emit.
//
//   Channel | Handshake               | Word
//   input   | in_valid_i / in_ready_o | value_i (signed, VALUE_BITS)
//   output  | out_valid_o/out_ready_i | char_code_o (8 bits), last_char_o
//
// A number of n characters (sign included) goes out as n output words, one character
// each; the single character serializer sets the rate, from 1 to 11 characters per
// number at the default width. The first character follows the magnitude stage, the
// double-dabble stages (four bits per stage), the digit-length stage and the output register.
// Reset clears all valid bits; output stalls back up the pipeline without loss.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_top #(
  parameter int unsigned VALUE_BITS = sitda_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [VALUE_BITS-1:0] value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [sitda_pkg::CHAR_W-1:0] char_code_o,
  output logic                         last_char_o
);
  import sitda_pkg::*;

  localparam int unsigned NumDigits = num_digits(VALUE_BITS);

  logic                  pipe_valid;
  logic                  pipe_ready;
  logic [NumDigits*4-1:0] pipe_bcd;
  num_info_t             pipe_info;

  sitda_bcd_pipe #(
    .VALUE_BITS(VALUE_BITS)
  ) u_pipe (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .value_i    (value_i),
    .out_valid_o(pipe_valid),
    .out_ready_i(pipe_ready),
    .bcd_o      (pipe_bcd),
    .info_o     (pipe_info)
  );

  sitda_emit #(
    .VALUE_BITS(VALUE_BITS)
  ) u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pipe_valid),
    .in_ready_o (pipe_ready),
    .bcd_i      (pipe_bcd),
    .info_i     (pipe_info),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .char_code_o(char_code_o),
    .last_char_o(last_char_o)
  );

endmodule

// File: tb/tb_signed_int_to_decimal_ascii_top.sv
// Self-checking testbench for signed_int_to_decimal_ascii_top.
// Drives signed words, predicts their decimal ASCII text and checks every output word.
// Depends on sitda_pkg and the converter RTL.
`timescale 1ns / 1ps

module tb_signed_int_to_decimal_ascii_top;

  import sitda_pkg::*;

  localparam int unsigned VALUE_BITS  = VALUE_BITS_DEF;
  localparam int unsigned DRAIN_WAIT  = 40;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_char_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_ready_o;
  logic signed [VALUE_BITS-1:0] value_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  logic [CHAR_W-1:0]            char_code_o;
  logic                         last_char_o;

  text_char_t  pending_text[$];
  int unsigned fail_count;
  int unsigned cycle_count;
  int unsigned in_idle_pct;
  int unsigned out_idle_pct;

  signed_int_to_decimal_ascii_top #(
    .VALUE_BITS(VALUE_BITS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .char_code_o(char_code_o),
    .last_char_o(last_char_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic void push_decimal_text(input logic [VALUE_BITS-1:0] word);
    logic [VALUE_BITS-1:0] magnitude;
    logic [3:0]            digit_buf[20];
    int                    n_digits;
    logic                  negative;
    text_char_t            c;
    negative  = word[VALUE_BITS-1];
    magnitude = negative ? (~word + 1'b1) : word;
    n_digits  = 0;
    do begin
      digit_buf[n_digits] = 4'(magnitude % 10);
      magnitude           = magnitude / 10;
      n_digits++;
    end while (magnitude != '0 && n_digits < 20);
    if (negative) begin
      c.code = CH_MINUS;
      c.last = 1'b0;
      pending_text.push_back(c);
    end
    for (int i = n_digits - 1; i >= 0; i--) begin
      c.code = CH_ZERO + CHAR_W'(digit_buf[i]);
      c.last = (i == 0);
      pending_text.push_back(c);
    end
  endfunction

  function automatic logic [VALUE_BITS-1:0] random_value();
    logic [63:0] ten_pow;
    logic [63:0] mag;
    int unsigned k;
    case ($urandom_range(3))
      0: begin
        return VALUE_BITS'($urandom);
      end
      1: begin
        mag = 64'($urandom_range(99));
      end
      2: begin
        k       = $urandom_range(1, 9);
        ten_pow = 64'd1;
        repeat (k) ten_pow = ten_pow * 64'd10;
        mag = 64'($urandom_range(0, 32'(ten_pow - 64'd1)));
      end
      default: begin
        k       = $urandom_range(0, 9);
        ten_pow = 64'd1;
        repeat (k) ten_pow = ten_pow * 64'd10;
        mag = ten_pow + 64'($urandom_range(2)) - 64'd1;
      end
    endcase
    return $urandom_range(1) ? VALUE_BITS'(-mag) : VALUE_BITS'(mag);
  endfunction

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= out_idle_pct);
  end

  always @(posedge clk_i) begin
    text_char_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_text.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
          $display("Unexpected word: char_code %0d last_char %0b", char_code_o, last_char_o);
        end
      end else begin
        want = pending_text.pop_front();
        if (char_code_o !== want.code || last_char_o !== want.last) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("Mismatch: expected char_code %0d last_char %0b, got %0d %0b",
                     want.code, want.last, char_code_o, last_char_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_word(input logic [VALUE_BITS-1:0] word);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= word;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    push_decimal_text(word);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_text.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    logic [VALUE_BITS-1:0] corner[$];
    corner = '{32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99, -32'sd100,
               32'sd2147483647, 32'h8000_0000, -32'sd2147483647, 32'sd1000000000,
               -32'sd999999999, 32'sd123456789, -32'sd5, 32'sd1000, 32'hAAAA_AAAA,
               32'h5555_5555, 32'sd999999999, -32'sd1000000000};
    foreach (corner[i]) send_word(corner[i]);
  endtask

  task automatic test_random_values(input int unsigned count);
    repeat (count) send_word(random_value());
  endtask

  task automatic test_drain_pause();
    repeat (20) send_word(random_value());
    wait_drained();
    repeat (20) send_word(random_value());
  endtask

  task automatic test_no_idling();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    repeat (60) send_word(random_value());
    in_idle_pct  = 10;
    out_idle_pct = 10;
  endtask

  initial begin
    fail_count   = 0;
    cycle_count  = 0;
    in_idle_pct  = 10;
    out_idle_pct = 10;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    value_i     <= '0;
    out_ready_i <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_drain_pause();
    test_random_values(130);
    test_no_idling();
    test_random_values(130);
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fail_count == 0 && pending_text.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: signed_int_to_decimal_ascii_top.f
+incdir+rtl
rtl/sitda_pkg.sv
rtl/sitda_bcd_pipe.sv
rtl/sitda_emit.sv
rtl/signed_int_to_decimal_ascii_top.sv
tb/tb_signed_int_to_decimal_ascii_top.sv
